@@ rtl/gmcp_pkg.sv @@
// Shared types, widths, register codes and saturating add for the grid coin path block.
`default_nettype none

package gmcp_pkg;

    localparam int COUNT_W   = 7;
    localparam int COINS_W   = 8;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 16'hFFFF;

    // Position of one cell within the grid
    typedef struct packed {
        logic row_first;
        logic col_first;
        logic is_final;
    } t_pos_flags;

    // Add coins to a total, clipping at the largest total
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [COINS_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {{(TOTAL_W + 1 - COINS_W){1'b0}}, b};
        return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/gmcp_row_mem.sv @@
// Row store of path totals: one write port, one read port with registered read data.
`default_nettype none

module gmcp_row_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write the new total
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read the total above; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/gmcp_pos.sv @@
// Configuration registers and raster position counters of the next cell.
`default_nettype none

module gmcp_pos #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int CW          = 6,
    parameter int RW          = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [gmcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gmcp_pkg::COUNT_W-1:0]      i_cfg_data,
    input  wire logic                              i_adv,
    output logic      [CW-1:0]                     o_col,
    output gmcp_pkg::t_pos_flags                   o_flags
);

    import gmcp_pkg::*;

    localparam int CCW = ($clog2(MAX_COLUMNS + 1) > COUNT_W) ? $clog2(MAX_COLUMNS + 1) : COUNT_W;
    localparam int RCW = ($clog2(MAX_ROWS + 1) > COUNT_W) ? $clog2(MAX_ROWS + 1) : COUNT_W;

    logic [COUNT_W-1:0] r_row_count;
    logic [COUNT_W-1:0] r_col_count;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [CCW-1:0]     col_cnt_ext;
    logic [RCW-1:0]     row_cnt_ext;
    logic [CW-1:0]      col_last;
    logic [RW-1:0]      row_last;
    logic               last_col;
    logic               last_row;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= COUNT_RESET;
            r_col_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_COUNT:    r_row_count <= i_cfg_data;
                REG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp counts to 1..MAX and form the last index
    assign col_cnt_ext = CCW'(r_col_count);
    assign row_cnt_ext = RCW'(r_row_count);

    always_comb begin
        if (col_cnt_ext == '0) begin
            col_last = '0;
        end else if (col_cnt_ext > CCW'(MAX_COLUMNS)) begin
            col_last = CW'(MAX_COLUMNS - 1);
        end else begin
            col_last = CW'(col_cnt_ext - CCW'(1));
        end
        if (row_cnt_ext == '0) begin
            row_last = '0;
        end else if (row_cnt_ext > RCW'(MAX_ROWS)) begin
            row_last = RW'(MAX_ROWS - 1);
        end else begin
            row_last = RW'(row_cnt_ext - RCW'(1));
        end
    end

    // An index at or past the last one ends the row or grid
    assign last_col = (r_col >= col_last);
    assign last_row = (r_row >= row_last);

    // Advance the raster position per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_col             = r_col;
    assign o_flags.row_first = (r_row == '0);
    assign o_flags.col_first = (r_col == '0);
    assign o_flags.is_final  = last_col && last_row;

endmodule

`default_nettype wire

@@ rtl/gmcp_cell.sv @@
// Cell update: best of up and left plus coins, with wall and edge blocking state.
`default_nettype none

module gmcp_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_move,
    input  wire gmcp_pkg::t_pos_flags          i_flags,
    input  wire logic [gmcp_pkg::COINS_W-1:0]  i_coins,
    input  wire logic                          i_wall,
    input  wire logic [gmcp_pkg::TOTAL_W-1:0]  i_up,
    output logic      [gmcp_pkg::TOTAL_W-1:0]  o_total
);

    import gmcp_pkg::*;

    logic [TOTAL_W-1:0] r_left_total;
    logic               r_top_blocked;
    logic               r_left_blocked;
    logic [TOTAL_W-1:0] best;
    logic               top_block;
    logic               left_block;

    assign best       = (i_up > r_left_total) ? i_up : r_left_total;
    assign left_block = i_wall || r_left_blocked;
    assign top_block  = i_wall || r_top_blocked;

    // Pick the total for this cell
    always_comb begin
        if (i_flags.row_first && i_flags.col_first) begin
            o_total = i_wall ? '0 : TOTAL_W'(i_coins);
        end else if (i_flags.col_first) begin
            o_total = left_block ? '0 : sat_add(i_up, i_coins);
        end else if (i_flags.row_first) begin
            o_total = top_block ? '0 : sat_add(r_left_total, i_coins);
        end else if (i_wall) begin
            o_total = '0;
        end else begin
            o_total = sat_add(best, i_coins);
        end
    end

    // Hold the left total; latch edge walls, drop them at the end of the grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_total   <= '0;
            r_top_blocked  <= 1'b0;
            r_left_blocked <= 1'b0;
        end else if (i_move) begin
            r_left_total <= o_total;
            if (i_flags.is_final) begin
                r_top_blocked  <= 1'b0;
                r_left_blocked <= 1'b0;
            end else if (!(i_flags.row_first && i_flags.col_first)) begin
                if (i_flags.col_first && left_block) begin
                    r_left_blocked <= 1'b1;
                end
                if (i_flags.row_first && top_block) begin
                    r_top_blocked <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/grid_max_coin_path_dp.sv @@
// Top level of the streaming best coin path block: input stage, row store and output register.
`default_nettype none

// Takes grid cells in raster order, one cell per clock at full rate while the
// output is not stalled, and gives for each the best right/down path coin
// total (saturating at 65535), flagging the bottom-right cell. A cell's result
// passes the cell stage and then the output register: the row store read of
// the total above happens as the cell is taken, the add and the output
// register load as it leaves the cell stage. The row of totals lives in one
// memory of MAX_COLUMNS entries with one read and one write port; with a
// one-column grid the entry just written is forwarded to the next read. The
// row store is not cleared at reset and needs no clearing pass. Write
// row_count and column_count only while no item is in flight.
module grid_max_coin_path_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gmcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gmcp_pkg::COUNT_W-1:0]    i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [gmcp_pkg::COINS_W-1:0]    i_coins,
    input  wire logic                            i_wall,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [gmcp_pkg::TOTAL_W-1:0]    o_best_total,
    output logic                                 o_is_final
);

    import gmcp_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);

    logic               accept;
    logic               out_free;
    logic               s1_move;
    logic [CW-1:0]      pos_col;
    t_pos_flags         pos_flags;
    logic [TOTAL_W-1:0] mem_rdata;
    logic [TOTAL_W-1:0] up_total;
    logic [TOTAL_W-1:0] cell_total;

    logic               r_s1_valid;
    logic [COINS_W-1:0] r_s1_coins;
    logic               r_s1_wall;
    t_pos_flags         r_s1_flags;
    logic [CW-1:0]      r_s1_col;
    logic               r_fwd_hit;
    logic [TOTAL_W-1:0] r_fwd_data;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_final;

    // Handshake: stall only when the cell stage is full and the output is full and stalled
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    gmcp_pos #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW),
        .RW          (RW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (accept),
        .o_col       (pos_col),
        .o_flags     (pos_flags)
    );

    gmcp_row_mem #(
        .DEPTH   (MAX_COLUMNS),
        .AW      (CW),
        .DW      (TOTAL_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (cell_total),
        .i_re    (accept),
        .i_raddr (pos_col),
        .o_rdata (mem_rdata)
    );

    // Forward the total written in the cycle of the read
    assign up_total = r_fwd_hit ? r_fwd_data : mem_rdata;

    gmcp_cell u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (s1_move),
        .i_flags (r_s1_flags),
        .i_coins (r_s1_coins),
        .i_wall  (r_s1_wall),
        .i_up    (up_total),
        .o_total (cell_total)
    );

    // Advance valid flags of the cell stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the cell stage with the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_coins <= i_coins;
            r_s1_wall  <= i_wall;
            r_s1_flags <= pos_flags;
            r_s1_col   <= pos_col;
            r_fwd_hit  <= s1_move && (r_s1_col == pos_col);
            r_fwd_data <= cell_total;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_total <= cell_total;
            r_out_final <= r_s1_flags.is_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_total = r_out_total;
    assign o_is_final   = r_out_final;

endmodule

`default_nettype wire

@@ rtl/gmcp_checker.sv @@
// Port-level checks of the grid coin path block, bound to its top level.
`default_nettype none

module gmcp_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            i_wall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [gmcp_pkg::TOTAL_W-1:0]    o_best_total,
    input wire logic                            o_is_final
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_best_total)
                                       && $stable(o_is_final))
        else $error("stalled result changed");

    // Input stalls only when the output is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // An accepted item reaches the output when the output is not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted item did not reach the output");

    // A wall cell gives a zero total
    a_wall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_wall) ##1 !i_out_stall
            |=> o_out_valid && (o_best_total == '0))
        else $error("wall cell gave a nonzero total");

endmodule

bind grid_max_coin_path_dp gmcp_checker u_gmcp_checker (.*);

`default_nettype wire
